// ===== sv/opd_pkg.sv =====
// Shared types, constants and state encoding for the occlusion position deviation core.
`timescale 1ns / 1ps
`default_nettype none
package opd_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HALF_DEF  = 3;
    localparam int MAX_HEIGHT    = 4096;

    localparam int POS_W  = 24;
    localparam int NRM_W  = 16;
    localparam int ROW_W  = 12;
    localparam int COL_W  = 10;
    localparam int DEV_W  = 24;
    localparam int CFG_W  = 11;
    localparam int FRAC_SHIFT = 14;

    localparam logic [DEV_W-1:0] DEV_MAX = {DEV_W{1'b1}};

    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH = 11'd640;
    localparam logic [1:0]       RST_PATCH_HALF  = 2'd1;

    localparam logic CFG_IMAGE_WIDTH = 1'b0;
    localparam logic CFG_PATCH_HALF  = 1'b1;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [NRM_W-1:0] norm_x;
        logic signed [NRM_W-1:0] norm_y;
        logic signed [NRM_W-1:0] norm_z;
        logic                    frame_start;
    } opd_in_t;

    typedef struct packed {
        logic [DEV_W-1:0] deviation;
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_col;
    } opd_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CENTER,
        ST_WIN,
        ST_DRAIN,
        ST_DIFF,
        ST_MUL,
        ST_PREP,
        ST_DIV,
        ST_OUT
    } opd_state_t;

    typedef struct packed {
        logic accept;
        logic center;
        logic win;
        logic diff;
        logic mul;
        logic prep;
        logic div;
        logic load_out;
    } opd_cmd_t;

    typedef struct packed {
        logic emit;
        logic win_last;
        logic mul_last;
        logic div_last;
        logic out_free;
    } opd_status_t;

endpackage
`default_nettype wire

// ===== sv/occlusion_position_deviation_core.sv =====
// Top level: occlusion position deviation core, controller plus datapath.
// A pixel with no complete window is taken while the controller stays idle.
// For a pixel that completes a window, the window walk reads one line store entry
// per cycle, and the divider yields one quotient bit per cycle.
// Results wait in an output register; the next pixel is taken while one waits there.
// Synchronous active-low reset clears counters, control and output valid, and sets the config to (640, 1).
`timescale 1ns / 1ps
`default_nettype none
module occlusion_position_deviation_core #(
    parameter int MAX_WIDTH = opd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HALF  = opd_pkg::MAX_HALF_DEF
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               cfg_we,
    input  wire               cfg_index,
    input  wire  [10:0]       cfg_wdata,
    input  wire               s_valid,
    output logic              s_ready,
    input  opd_pkg::opd_in_t  s_data,
    output logic              m_valid,
    input  wire               m_ready,
    output opd_pkg::opd_out_t m_data
);
    import opd_pkg::*;

    opd_cmd_t    cmd;
    opd_status_t status;

    opd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    opd_datapath #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HALF  (MAX_HALF)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .status    (status),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire

// ===== sv/opd_ctrl.sv =====
// Sequencing state machine for the occlusion position deviation core.
`timescale 1ns / 1ps
`default_nettype none
module opd_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  opd_pkg::opd_status_t status,
    output opd_pkg::opd_cmd_t    cmd
);
    import opd_pkg::*;

    opd_state_t state_reg;
    opd_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && status.emit) begin
                    state_next = ST_CENTER;
                end
            end
            ST_CENTER: state_next = ST_WIN;
            ST_WIN: begin
                if (status.win_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_MUL;
            ST_MUL: begin
                if (status.mul_last) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: state_next = ST_DIV;
            ST_DIV: begin
                if (status.div_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            ST_CENTER: cmd.center   = 1'b1;
            ST_WIN:    cmd.win      = 1'b1;
            ST_DRAIN:  cmd          = '0;
            ST_DIFF:   cmd.diff     = 1'b1;
            ST_MUL:    cmd.mul      = 1'b1;
            ST_PREP:   cmd.prep     = 1'b1;
            ST_DIV:    cmd.div      = 1'b1;
            ST_OUT:    cmd.load_out = status.out_free;
            default:   cmd          = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/opd_datapath.sv =====
// Line stores, window accumulator, dot product and divider of the deviation core.
`timescale 1ns / 1ps
`default_nettype none
module opd_datapath #(
    parameter int MAX_WIDTH = opd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HALF  = opd_pkg::MAX_HALF_DEF
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  cfg_we,
    input  wire                  cfg_index,
    input  wire  [10:0]          cfg_wdata,
    input  opd_pkg::opd_in_t     s_data,
    input  opd_pkg::opd_cmd_t    cmd,
    output opd_pkg::opd_status_t status,
    input  wire                  m_ready,
    output logic                 m_valid,
    output opd_pkg::opd_out_t    m_data
);
    import opd_pkg::*;

    localparam int SLOTS = 2 * MAX_HALF + 1;
    localparam int SLW   = $clog2(SLOTS);
    localparam int CW    = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int HW    = $clog2(MAX_HALF + 1);
    localparam int NW    = $clog2(SLOTS * SLOTS + 1);
    localparam int KW    = $clog2(MAX_HALF * SLOTS + 1);
    localparam int AW    = SLW + CW;
    localparam int DEPTH = SLOTS << CW;
    localparam int SUMW  = POS_W + NW;
    localparam int DIFFW = SUMW + 2;
    localparam int PRODW = NRM_W + DIFFW;
    localparam int TW    = PRODW + 2;
    localparam int QW    = TW + 1 - FRAC_SHIFT;
    localparam int DCW   = $clog2(QW);

    // configuration
    logic [CFG_W-1:0] width_cfg_reg;
    logic [1:0]       half_cfg_reg;
    logic [HW-1:0]    h_eff;
    logic [15:0]      w_eff16;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg <= RST_IMAGE_WIDTH;
            half_cfg_reg  <= RST_PATCH_HALF;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH: width_cfg_reg <= cfg_wdata;
                CFG_PATCH_HALF:  half_cfg_reg  <= cfg_wdata[1:0];
                default:         width_cfg_reg <= width_cfg_reg;
            endcase
        end
    end

    always_comb begin
        if (half_cfg_reg == 2'd0) begin
            h_eff = HW'(1);
        end else if (16'(half_cfg_reg) > 16'(MAX_HALF)) begin
            h_eff = HW'(MAX_HALF);
        end else begin
            h_eff = HW'(half_cfg_reg);
        end
        if (width_cfg_reg == '0) begin
            w_eff16 = 16'd1;
        end else if (16'(width_cfg_reg) > 16'(MAX_WIDTH)) begin
            w_eff16 = 16'(MAX_WIDTH);
        end else begin
            w_eff16 = 16'(width_cfg_reg);
        end
    end

    // raster position
    logic [ROW_W-1:0] row_count_reg, row_count_next;
    logic [CW-1:0]    col_count_reg, col_count_next;
    logic [SLW-1:0]   slot_count_reg, slot_count_next;
    logic [ROW_W-1:0] r_in;
    logic [CW-1:0]    c_in;
    logic [SLW-1:0]   slot_in;
    logic [ROW_W:0]   row_inc;
    logic [15:0]      two_h16;

    always_comb begin
        r_in    = s_data.frame_start ? '0 : row_count_reg;
        c_in    = s_data.frame_start ? '0 : col_count_reg;
        slot_in = s_data.frame_start ? '0 : slot_count_reg;
        two_h16 = 16'(h_eff) << 1;
        row_inc = {1'b0, r_in} + 1'b1;
        if (16'(c_in) + 16'd1 >= w_eff16) begin
            col_count_next = '0;
            if (row_inc == (ROW_W+1)'(MAX_HEIGHT)) begin
                row_count_next  = '0;
                slot_count_next = '0;
            end else begin
                row_count_next  = row_inc[ROW_W-1:0];
                slot_count_next = (slot_in == SLW'(SLOTS - 1)) ? '0 : slot_in + 1'b1;
            end
        end else begin
            col_count_next  = c_in + 1'b1;
            row_count_next  = r_in;
            slot_count_next = slot_in;
        end
    end

    assign status.emit = (16'(r_in) >= two_h16) && (16'(c_in) >= two_h16);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg  <= '0;
            col_count_reg  <= '0;
            slot_count_reg <= '0;
        end else if (cmd.accept) begin
            row_count_reg  <= row_count_next;
            col_count_reg  <= col_count_next;
            slot_count_reg <= slot_count_next;
        end
    end

    // item being worked on
    logic [ROW_W-1:0] row_w_reg;
    logic [CW-1:0]    col_w_reg;
    logic [SLW-1:0]   slot_w_reg;
    logic [HW-1:0]    h_w_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            row_w_reg  <= r_in;
            col_w_reg  <= c_in;
            slot_w_reg <= slot_in;
            h_w_reg    <= h_eff;
        end
    end

    function automatic logic [SLW-1:0] slot_sub(input logic [SLW-1:0] s,
                                                input logic [HW:0] d);
        logic [SLW:0] t;
        t = {1'b0, s} + (SLW+1)'(SLOTS) - (SLW+1)'(d);
        if (t >= (SLW+1)'(SLOTS)) begin
            t = t - (SLW+1)'(SLOTS);
        end
        return t[SLW-1:0];
    endfunction

    logic [HW:0]    two_h_w;
    logic [SLW-1:0] cen_slot, start_slot;
    logic [CW-1:0]  cen_col, base_col;
    logic [NW-1:0]  n_val;
    logic [KW-1:0]  k_val;

    always_comb begin
        two_h_w    = {h_w_reg, 1'b0};
        cen_slot   = slot_sub(slot_w_reg, {1'b0, h_w_reg});
        start_slot = slot_sub(slot_w_reg, two_h_w);
        cen_col    = col_w_reg - CW'(h_w_reg);
        base_col   = col_w_reg - CW'(two_h_w);
        n_val      = NW'(two_h_w + 1'b1) * NW'(two_h_w + 1'b1);
        k_val      = KW'(h_w_reg) * KW'(two_h_w + 1'b1);
    end

    // window walk
    logic [SLW-1:0] i_reg, j_reg, win_slot_reg;
    logic [CW-1:0]  col_base_reg;

    assign status.win_last = (i_reg == SLW'(two_h_w)) && (j_reg == SLW'(two_h_w));

    always_ff @(posedge aclk) begin
        if (cmd.center) begin
            i_reg        <= '0;
            j_reg        <= '0;
            win_slot_reg <= start_slot;
            col_base_reg <= base_col;
        end else if (cmd.win) begin
            if (j_reg == SLW'(two_h_w)) begin
                j_reg        <= '0;
                i_reg        <= i_reg + 1'b1;
                win_slot_reg <= (win_slot_reg == SLW'(SLOTS - 1)) ? '0 : win_slot_reg + 1'b1;
            end else begin
                j_reg <= j_reg + 1'b1;
            end
        end
    end

    // line stores
    logic signed [POS_W-1:0]   mem_x [DEPTH];
    logic signed [POS_W-1:0]   mem_y [DEPTH];
    logic signed [POS_W-1:0]   mem_z [DEPTH];
    logic [3*NRM_W-1:0]        mem_n [DEPTH];
    logic [AW-1:0]             wr_addr, rd_addr;
    logic signed [POS_W-1:0]   rdx_reg, rdy_reg, rdz_reg;
    logic [3*NRM_W-1:0]        rdn_reg;

    assign wr_addr = {slot_in, c_in};
    assign rd_addr = cmd.center ? {cen_slot, cen_col}
                                : {win_slot_reg, col_base_reg + CW'(j_reg)};

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            mem_x[wr_addr] <= s_data.pos_x;
            mem_y[wr_addr] <= s_data.pos_y;
            mem_z[wr_addr] <= s_data.pos_z;
            mem_n[wr_addr] <= {s_data.norm_x, s_data.norm_y, s_data.norm_z};
        end
        rdx_reg <= mem_x[rd_addr];
        rdy_reg <= mem_y[rd_addr];
        rdz_reg <= mem_z[rd_addr];
        rdn_reg <= mem_n[rd_addr];
    end

    // accumulate
    logic                    cen_pend_reg, acc_pend_reg;
    logic signed [SUMW-1:0]  sum_x_reg, sum_y_reg, sum_z_reg;
    logic signed [POS_W-1:0] pcx_reg, pcy_reg, pcz_reg;
    logic signed [NRM_W-1:0] ncx_reg, ncy_reg, ncz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cen_pend_reg <= 1'b0;
            acc_pend_reg <= 1'b0;
        end else begin
            cen_pend_reg <= cmd.center;
            acc_pend_reg <= cmd.win;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.center) begin
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            sum_z_reg <= '0;
        end else if (acc_pend_reg) begin
            sum_x_reg <= sum_x_reg + SUMW'(rdx_reg);
            sum_y_reg <= sum_y_reg + SUMW'(rdy_reg);
            sum_z_reg <= sum_z_reg + SUMW'(rdz_reg);
        end
        if (cen_pend_reg) begin
            pcx_reg <= rdx_reg;
            pcy_reg <= rdy_reg;
            pcz_reg <= rdz_reg;
            ncx_reg <= rdn_reg[3*NRM_W-1:2*NRM_W];
            ncy_reg <= rdn_reg[2*NRM_W-1:NRM_W];
            ncz_reg <= rdn_reg[NRM_W-1:0];
        end
    end

    // centre-removed sums and dot product
    logic signed [NW:0]          n_s;
    logic signed [NW+POS_W:0]    npx, npy, npz;
    logic signed [DIFFW-1:0]     diff_x_reg, diff_y_reg, diff_z_reg;
    logic [1:0]                  mul_k_reg;
    logic signed [NRM_W-1:0]     mul_n;
    logic signed [DIFFW-1:0]     mul_d;
    logic signed [PRODW-1:0]     prod;
    logic signed [TW-1:0]        t_reg;

    assign n_s = $signed({1'b0, n_val});
    assign npx = n_s * pcx_reg;
    assign npy = n_s * pcy_reg;
    assign npz = n_s * pcz_reg;
    assign status.mul_last = (mul_k_reg == 2'd2);

    always_comb begin
        case (mul_k_reg)
            2'd0: begin
                mul_n = ncx_reg;
                mul_d = diff_x_reg;
            end
            2'd1: begin
                mul_n = ncy_reg;
                mul_d = diff_y_reg;
            end
            default: begin
                mul_n = ncz_reg;
                mul_d = diff_z_reg;
            end
        endcase
        prod = mul_n * mul_d;
    end

    always_ff @(posedge aclk) begin
        if (cmd.diff) begin
            diff_x_reg <= DIFFW'(sum_x_reg) - DIFFW'(npx);
            diff_y_reg <= DIFFW'(sum_y_reg) - DIFFW'(npy);
            diff_z_reg <= DIFFW'(sum_z_reg) - DIFFW'(npz);
            mul_k_reg  <= '0;
            t_reg      <= '0;
        end else if (cmd.mul) begin
            t_reg     <= t_reg + TW'(prod);
            mul_k_reg <= mul_k_reg + 1'b1;
        end
    end

    // rounded division by h*(2h+1) scaled by 2^FRAC_SHIFT, one quotient bit per cycle
    logic [TW-1:0]  mag;
    logic [TW:0]    num_full;
    logic [QW-1:0]  q_reg;
    logic [KW-1:0]  rem_reg;
    logic [KW:0]    rem_sh;
    logic [DCW-1:0] div_cnt_reg;

    assign mag      = t_reg[TW-1] ? TW'(-t_reg) : '0;
    assign num_full = {1'b0, mag} + ((TW+1)'(k_val) << (FRAC_SHIFT - 1));
    assign rem_sh   = {rem_reg, q_reg[QW-1]};
    assign status.div_last = (div_cnt_reg == DCW'(QW - 1));

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            q_reg       <= num_full[TW:FRAC_SHIFT];
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end else if (cmd.div) begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
            if (rem_sh >= (KW+1)'(k_val)) begin
                rem_reg <= KW'(rem_sh - (KW+1)'(k_val));
                q_reg   <= {q_reg[QW-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[KW-1:0];
                q_reg   <= {q_reg[QW-2:0], 1'b0};
            end
        end
    end

    // result register
    logic             m_valid_reg;
    opd_out_t         m_data_reg;
    logic [DEV_W-1:0] dev;

    assign dev = (q_reg > QW'(DEV_MAX)) ? DEV_MAX : q_reg[DEV_W-1:0];
    assign status.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_data_reg.deviation <= dev;
            m_data_reg.out_row   <= row_w_reg - ROW_W'(h_w_reg);
            m_data_reg.out_col   <= COL_W'(cen_col);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

// ===== sim/occlusion_position_deviation_core_test.sv =====
// Self-checking testbench for the occlusion position deviation core.
`timescale 1ns / 1ps
`default_nettype none
module occlusion_position_deviation_core_test;
    import opd_pkg::*;

    localparam int SLOTS = 7;
    localparam int WIDTH_CAP = 1024;
    localparam int HALF_CAP = 3;
    localparam longint CYCLE_LIMIT = 500000;
    localparam int SETTLE_CYCLES = 120;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_index = CFG_IMAGE_WIDTH;
    logic [10:0] cfg_wdata = '0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    opd_in_t    s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    opd_out_t   m_data;

    occlusion_position_deviation_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    longint cycles = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // shadow of the block
    int width_reg = 640;
    int half_reg = 1;
    int row_pos = 0;
    int col_pos = 0;
    int px_store [SLOTS][WIDTH_CAP];
    int py_store [SLOTS][WIDTH_CAP];
    int pz_store [SLOTS][WIDTH_CAP];
    int nrm_store [SLOTS][WIDTH_CAP][3];
    opd_out_t deviation_q[$];

    int  mismatches = 0;
    bit  gaps_on = 1'b1;
    int  hold_req = 0;
    bit  started = 1'b0;

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 20)
            $display("mismatch @%0d: %s", cycles, what);
    endtask

    function automatic void predict_deviation(opd_in_t px);
        int w, h, r, c, slot, cr, cs, cc, s;
        longint sx, sy, sz, n, t, mag, den, dev;
        opd_out_t res;
        w = width_reg;
        h = half_reg;
        if (w < 1) w = 1;
        if (w > WIDTH_CAP) w = WIDTH_CAP;
        if (h < 1) h = 1;
        if (h > HALF_CAP) h = HALF_CAP;
        if (px.frame_start) begin
            row_pos = 0;
            col_pos = 0;
        end
        r = row_pos;
        c = col_pos;
        slot = r % SLOTS;
        px_store[slot][c] = int'(px.pos_x);
        py_store[slot][c] = int'(px.pos_y);
        pz_store[slot][c] = int'(px.pos_z);
        nrm_store[slot][c][0] = int'(px.norm_x);
        nrm_store[slot][c][1] = int'(px.norm_y);
        nrm_store[slot][c][2] = int'(px.norm_z);
        if (r >= 2*h && c >= 2*h) begin
            cr = r - h;
            cc = c - h;
            cs = cr % SLOTS;
            sx = 0; sy = 0; sz = 0;
            for (int i = 0; i <= 2*h; i++) begin
                s = (r - 2*h + i) % SLOTS;
                for (int j = 0; j <= 2*h; j++) begin
                    sx += px_store[s][c - 2*h + j];
                    sy += py_store[s][c - 2*h + j];
                    sz += pz_store[s][c - 2*h + j];
                end
            end
            n = longint'((2*h + 1) * (2*h + 1));
            sx -= n * px_store[cs][cc];
            sy -= n * py_store[cs][cc];
            sz -= n * pz_store[cs][cc];
            t = longint'(nrm_store[cs][cc][0]) * sx + longint'(nrm_store[cs][cc][1]) * sy
              + longint'(nrm_store[cs][cc][2]) * sz;
            dev = 0;
            if (t < 0) begin
                mag = -t;
                den = longint'(h * (2*h + 1)) << FRAC_SHIFT;
                dev = (mag + den / 2) / den;
                if (dev > longint'(DEV_MAX)) dev = longint'(DEV_MAX);
            end
            res.deviation = dev[DEV_W-1:0];
            res.out_row = cr[ROW_W-1:0];
            res.out_col = cc[COL_W-1:0];
            deviation_q.push_back(res);
        end
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1) % MAX_HEIGHT;
        end else begin
            col_pos = c + 1;
        end
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (!gaps_on || p < 60) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: random stalls, long hold-offs on request
    initial begin : result_checker
        int stall_left;
        opd_out_t want;
        stall_left = 0;
        wait (started);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (deviation_q.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    want = deviation_q.pop_front();
                    if (m_data.deviation !== want.deviation)
                        report_mismatch($sformatf("deviation %0d, want %0d (row %0d col %0d)",
                            m_data.deviation, want.deviation, want.out_row, want.out_col));
                    if (m_data.out_row !== want.out_row)
                        report_mismatch($sformatf("out_row %0d, want %0d",
                            m_data.out_row, want.out_row));
                    if (m_data.out_col !== want.out_col)
                        report_mismatch($sformatf("out_col %0d, want %0d",
                            m_data.out_col, want.out_col));
                end
            end
            if (hold_req > 0) begin
                stall_left = hold_req;
                hold_req = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!gaps_on || $urandom_range(0, 99) < 70) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                        : $urandom_range(0, 3);
            end
        end
    end

    task automatic send_pixel(input opd_in_t px);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data <= px;
        s_valid <= 1'b1;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        predict_deviation(px);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (deviation_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input int value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[10:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_IMAGE_WIDTH) width_reg = value & 'h7FF;
        else half_reg = value & 'h3;
    endtask

    task automatic set_geometry(input int w, input int h);
        drain();
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_PATCH_HALF, h);
    endtask

    function automatic logic [POS_W-1:0] rand_pos();
        logic [POS_W-1:0] v;
        v = POS_W'($urandom);
        case ($urandom_range(0, 3))
            0: v = {{14{v[9]}}, v[9:0]};
            1: v = {{8{v[15]}}, v[15:0]};
            2: v = {{4{v[19]}}, v[19:0]};
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [NRM_W-1:0] rand_norm();
        int v;
        if ($urandom_range(0, 9) == 0) return NRM_W'($urandom);
        v = $urandom_range(0, 32768);
        v = v - 16384;
        return v[NRM_W-1:0];
    endfunction

    function automatic opd_in_t rand_pixel(input bit fs);
        opd_in_t px;
        px.pos_x = rand_pos();
        px.pos_y = rand_pos();
        px.pos_z = rand_pos();
        px.norm_x = rand_norm();
        px.norm_y = rand_norm();
        px.norm_z = rand_norm();
        px.frame_start = fs;
        return px;
    endfunction

    function automatic opd_in_t make_pixel(input int x, y, z, nx, ny, nz, input bit fs);
        opd_in_t px;
        px.pos_x = POS_W'(x);
        px.pos_y = POS_W'(y);
        px.pos_z = POS_W'(z);
        px.norm_x = NRM_W'(nx);
        px.norm_y = NRM_W'(ny);
        px.norm_z = NRM_W'(nz);
        px.frame_start = fs;
        return px;
    endfunction

    task automatic send_frame(input int rows, input int w, input int noise_pct);
        for (int i = 0; i < rows * w; i++)
            send_pixel(rand_pixel(i == 0 || $urandom_range(0, 999) < noise_pct));
    endtask

    // extremes, zero patch half, zero width, narrow image
    task automatic test_directed();
        set_geometry(3, 0);
        for (int i = 0; i < 9; i++) begin
            if (i == 4)
                send_pixel(make_pixel(-8388608, 8388607, -8388608, 16384, -16384, -32768, 0));
            else if (i[0])
                send_pixel(make_pixel(8388607, -8388608, 8388607, 0, 0, 0, 0));
            else
                send_pixel(make_pixel(-8388608, 8388607, -8388608, 32767, -1, 1, i == 0));
        end
        for (int i = 0; i < 3; i++)
            send_pixel(make_pixel(16 * i, -16 * i, 0, -16384, 16384, 0, 0));
        set_geometry(0, 1);
        for (int i = 0; i < 4; i++) send_pixel(rand_pixel(i == 0));
        set_geometry(4, 2);
        for (int i = 0; i < 8; i++) send_pixel(rand_pixel(i == 0));
    endtask

    task automatic test_random_frames();
        int shapes [6][2] = '{'{5, 1}, '{7, 3}, '{12, 2}, '{9, 3}, '{3, 1}, '{16, 1}};
        for (int k = 0; k < 6; k++) begin
            set_geometry(shapes[k][0], shapes[k][1]);
            gaps_on = (k != 2);
            send_frame(90 / shapes[k][0] + 2 * shapes[k][1], shapes[k][0], 15);
        end
        gaps_on = 1'b1;
    endtask

    // long result hold-off while pixels keep coming, then a full pause
    task automatic test_backpressure();
        set_geometry(3, 1);
        hold_req = 400;
        gaps_on = 1'b0;
        send_frame(25, 3, 0);
        gaps_on = 1'b1;
        drain();
        send_frame(6, 3, 0);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        started = 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_frames();
        test_backpressure();
        drain();
        if (mismatches == 0 && deviation_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire
